// ----- src/tmaq_pkg.sv -----
// Package for the timed mouse action queue: event and action codes,
// queue entry and report types, the motion clamp function.
// No dependencies.
package tmaq_pkg;

    localparam int QUEUE_DEPTH_DFLT = 512;

    typedef logic [2:0] t_kind;
    localparam t_kind KIND_PUSH    = 3'd0;
    localparam t_kind KIND_TICK    = 3'd1;
    localparam t_kind KIND_SERVICE = 3'd2;
    localparam t_kind KIND_SENT    = 3'd3;
    localparam t_kind KIND_RELEASE = 3'd4;
    localparam t_kind KIND_DIRECT  = 3'd5;

    typedef logic [2:0] t_action;
    localparam t_action ACT_IDLE    = 3'd0;
    localparam t_action ACT_BUTTONS = 3'd1;
    localparam t_action ACT_DELAY   = 3'd2;
    localparam t_action ACT_REPORT  = 3'd3;
    localparam t_action ACT_RESET   = 3'd4;

    localparam logic [4:0] BTN_BITS = 5'h1F;
    localparam logic signed [7:0] MOTION_MAX = 8'sd127;
    localparam logic signed [7:0] MOTION_MIN = -8'sd127;

    typedef struct packed {
        logic signed [7:0] pan;
        logic signed [7:0] wheel;
        logic signed [7:0] y;
        logic signed [7:0] x;
    } t_motion;

    typedef struct packed {
        t_motion     motion;
        logic [4:0]  buttons;
        logic [15:0] delay;
        t_action     atype;
    } t_entry;

    typedef struct packed {
        logic        pending;
        logic [4:0]  buttons;
        t_motion     motion;
    } t_report;

    typedef enum logic [1:0] {
        RPT_HOLD,
        RPT_SET,
        RPT_SENT
    } t_rpt_op;

    typedef struct packed {
        t_rpt_op     op;
        logic [4:0]  buttons;
        t_motion     motion;
    } t_rpt_cmd;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    function automatic logic signed [7:0] clamp8(input logic signed [7:0] v);
        logic signed [7:0] r;
        r = v;
        if (v < MOTION_MIN) r = MOTION_MIN;
        if (v > MOTION_MAX) r = MOTION_MAX;
        return r;
    endfunction

endpackage

// ----- src/tmaq_report.sv -----
// Held mouse report: buttons, four motion lanes and the pending mark.
// Applies set and sent commands from the queue control. Uses tmaq_pkg.
module tmaq_report (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tmaq_pkg::t_rpt_cmd i_cmd,
    output tmaq_pkg::t_report  o_held
);
    import tmaq_pkg::*;

    t_report r_held;
    t_report n_held;

    always_comb begin
        n_held = r_held;
        case (i_cmd.op)
            RPT_SET: begin
                n_held.pending = 1'b1;
                n_held.buttons = i_cmd.buttons & BTN_BITS;
                n_held.motion  = i_cmd.motion;
            end
            RPT_SENT: begin
                n_held.pending = 1'b0;
                n_held.motion  = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else begin
            r_held <= n_held;
        end
    end

    assign o_held = r_held;

endmodule

// ----- src/timed_mouse_action_queue.sv -----
// Timed mouse action queue: ring FIFO of timed actions in one memory,
// countdown and service control. Uses tmaq_pkg and tmaq_report.
//
//   channel  | valid    | stall    | payload
//   ---------+----------+----------+-----------------------------------------
//   input    | i_valid  | o_stall  | i_kind .. i_pan
//   output   | o_valid  | i_stall  | o_push_ok .. o_report_pan
//
// Each item goes through an accept cycle, in which the head entry is read
// from the action memory, and then an execute cycle that updates queue and report.
// An item waits in execute while the previous result is still stalled.
// Reset is synchronous and clears control and report; the memory is not cleared.
module timed_mouse_action_queue #(
    parameter int QUEUE_DEPTH = tmaq_pkg::QUEUE_DEPTH_DFLT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  tmaq_pkg::t_kind   i_kind,
    input  logic [2:0]        i_action_type,
    input  logic [15:0]       i_delay_ms,
    input  logic [4:0]        i_buttons,
    input  logic signed [7:0] i_dx,
    input  logic signed [7:0] i_dy,
    input  logic signed [7:0] i_wheel,
    input  logic signed [7:0] i_pan,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_push_ok,
    output logic              o_executed,
    output logic [8:0]        o_queue_count,
    output logic              o_report_pending,
    output logic [4:0]        o_report_buttons,
    output logic signed [7:0] o_report_x,
    output logic signed [7:0] o_report_y,
    output logic signed [7:0] o_report_wheel,
    output logic signed [7:0] o_report_pan
);
    import tmaq_pkg::*;

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);
    localparam logic [IW:0]   DEPTH_W  = (IW+1)'(QUEUE_DEPTH);

    t_state r_state, n_state;

    t_kind       r_kind;
    t_action     r_atype;
    logic [15:0] r_delay;
    logic [4:0]  r_btn;
    t_motion     r_motion;

    logic [IW-1:0] r_head, n_head;
    logic [IW-1:0] r_tail, n_tail;
    logic          r_armed, n_armed;
    logic [15:0]   r_left, n_left;
    logic          r_valid, n_valid;
    logic          r_push_ok, n_push_ok;
    logic          r_executed, n_executed;

    t_entry mem [QUEUE_DEPTH];
    t_entry r_rd;
    t_entry wr_entry;
    logic   mem_we;

    logic          in_xfer;
    logic          out_free;
    logic          exec;
    logic [IW-1:0] head_inc;
    logic [IW-1:0] tail_inc;
    logic [15:0]   left_now;
    logic          blockable;
    logic [IW:0]   count;

    t_rpt_cmd rpt_cmd;
    t_report  held;

    tmaq_report u_report (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (rpt_cmd),
        .o_held  (held)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid) n_state = S_EXEC;
            S_EXEC: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_stall  = 1'b1;
        in_xfer  = 1'b0;
        exec     = 1'b0;
        out_free = !r_valid || !i_stall;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                in_xfer = i_valid;
            end
            S_EXEC: exec = out_free;
            default: ;
        endcase
    end

    assign head_inc = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign tail_inc = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
    assign left_now = r_armed ? r_left : r_rd.delay;
    assign blockable = r_rd.atype inside {ACT_BUTTONS, ACT_REPORT, ACT_RESET};

    always_comb begin
        wr_entry.atype   = r_atype;
        wr_entry.delay   = r_delay;
        wr_entry.buttons = r_btn;
        wr_entry.motion  = r_motion;
    end

    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_armed    = r_armed;
        n_left     = r_left;
        n_push_ok  = 1'b0;
        n_executed = 1'b0;
        mem_we     = 1'b0;
        rpt_cmd    = '{op: RPT_HOLD, buttons: '0, motion: '0};
        if (exec) begin
            case (r_kind)
                KIND_PUSH: begin
                    if (tail_inc != r_head) begin
                        mem_we    = 1'b1;
                        n_tail    = tail_inc;
                        n_push_ok = 1'b1;
                    end
                end
                KIND_TICK: begin
                    if (r_armed && r_left != '0) n_left = r_left - 1'b1;
                end
                KIND_SERVICE: begin
                    if (r_head != r_tail) begin
                        n_armed = 1'b1;
                        n_left  = left_now;
                        if (left_now == '0 && !(held.pending && blockable)) begin
                            n_executed = 1'b1;
                            n_armed    = 1'b0;
                            n_left     = '0;
                            n_head     = head_inc;
                            case (r_rd.atype)
                                ACT_BUTTONS: begin
                                    rpt_cmd.op      = RPT_SET;
                                    rpt_cmd.buttons = r_rd.buttons;
                                end
                                ACT_REPORT: begin
                                    rpt_cmd.op      = RPT_SET;
                                    rpt_cmd.buttons = r_rd.buttons;
                                    rpt_cmd.motion  = r_rd.motion;
                                end
                                ACT_RESET: begin
                                    rpt_cmd.op = RPT_SET;
                                    n_head     = '0;
                                    n_tail     = '0;
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                KIND_SENT: rpt_cmd.op = RPT_SENT;
                KIND_RELEASE: begin
                    rpt_cmd.op = RPT_SET;
                    n_head     = '0;
                    n_tail     = '0;
                    n_armed    = 1'b0;
                    n_left     = '0;
                end
                KIND_DIRECT: begin
                    rpt_cmd.op      = RPT_SET;
                    rpt_cmd.buttons = r_btn;
                    rpt_cmd.motion  = r_motion;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        if (exec) n_valid = 1'b1;
        else if (!i_stall) n_valid = 1'b0;
        else n_valid = r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[r_tail] <= wr_entry;
        r_rd <= mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_kind          <= i_kind;
            r_atype         <= i_action_type;
            r_delay         <= i_delay_ms;
            r_btn           <= i_buttons & BTN_BITS;
            r_motion.x      <= clamp8(i_dx);
            r_motion.y      <= clamp8(i_dy);
            r_motion.wheel  <= clamp8(i_wheel);
            r_motion.pan    <= clamp8(i_pan);
        end
        if (exec) begin
            r_push_ok  <= n_push_ok;
            r_executed <= n_executed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_armed <= 1'b0;
            r_left  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_armed <= n_armed;
            r_left  <= n_left;
            r_valid <= n_valid;
        end
    end

    assign count = (r_tail >= r_head) ? {1'b0, r_tail} - {1'b0, r_head}
                                      : {1'b0, r_tail} + DEPTH_W - {1'b0, r_head};

    assign o_valid          = r_valid;
    assign o_push_ok        = r_push_ok;
    assign o_executed       = r_executed;
    assign o_queue_count    = 9'(count);
    assign o_report_pending = held.pending;
    assign o_report_buttons = held.buttons;
    assign o_report_x       = held.motion.x;
    assign o_report_y       = held.motion.y;
    assign o_report_wheel   = held.motion.wheel;
    assign o_report_pan     = held.motion.pan;

endmodule

// ----- src/tmaq_checker.sv -----
// Port-level checks for the timed mouse action queue, bound to the top level.
// No package dependency.
module tmaq_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input logic              o_push_ok,
    input logic              o_executed,
    input logic [8:0]        o_queue_count,
    input logic              o_report_pending,
    input logic [4:0]        o_report_buttons,
    input logic signed [7:0] o_report_x,
    input logic signed [7:0] o_report_y,
    input logic signed [7:0] o_report_wheel,
    input logic signed [7:0] o_report_pan
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second transfer taken while an item is at work");

    a_push_or_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_push_ok && o_executed))
        else $error("push and execute flagged on one result");

    a_sent_motion: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_report_pending |-> (o_report_x == 8'sd0 && o_report_y == 8'sd0 &&
                               o_report_wheel == 8'sd0 && o_report_pan == 8'sd0))
        else $error("motion held with no report pending");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_queue_count) &&
                               $stable(o_report_buttons))
        else $error("stalled result changed");

endmodule

bind timed_mouse_action_queue tmaq_checker u_tmaq_checker (.*);
